### hw/rtl/opt_pkg.sv
// Package for the ordered process table: record layout, opcodes and sizes.
`timescale 1ns / 1ps
`default_nettype none

package opt_pkg;

    // Default number of records the table holds
    localparam int unsigned OPT_TABLE_DEPTH = 16;

    // Field widths
    localparam int unsigned ID_W    = 16;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned OUT_CNT_W = 5;

    // Stream widths
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned M_TUSER_W = 1;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } opt_op_t;

    // One stored record, 56 bits
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] io;
        logic [BURST_W-1:0] cpu;
        logic [ID_W-1:0]    id;
    } opt_rec_t;

endpackage : opt_pkg

`default_nettype wire

### hw/rtl/opt_rec_mem.sv
// Record store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module opt_rec_mem
    import opt_pkg::*;
#(
    parameter int unsigned DEPTH  = OPT_TABLE_DEPTH,
    parameter int unsigned ADDR_W = $clog2(OPT_TABLE_DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire opt_rec_t          wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output opt_rec_t               rd_data
);

    opt_rec_t store_reg [DEPTH];
    opt_rec_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : opt_rec_mem

`default_nettype wire

### hw/rtl/ordered_process_table_core.sv
// Top level of the ordered process table: sequencer, count and result register.
//
//  channel | dir | beat contents (low bits first)
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | tuser: opcode; tdata: id, cpu burst, io burst, priority
//  m_      | out | tuser: ok; tdata: id, cpu, io, priority, count, empty flag
//
// Lookup and delete scan the record memory one entry a cycle through its single
// read port, and delete then moves the later records down.
// One operation is in flight at a time; a new beat is taken once the result
// sits in the output register, even if the sink has not taken it yet.
// Reset clears the sequencer, the count and the output valid; the record
// memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module ordered_process_table_core
    import opt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = OPT_TABLE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input beat
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // proc_id, cpu_burst_in, io_burst_in, priority_in
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // opcode
    // result beat
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // found_id, cpu_burst_out, io_burst_out,
                                                // priority_out, entry_count, is_empty, pad
    output logic [M_TUSER_W-1:0]      m_tuser   // ok
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [S_TUSER_W-1:0] op_reg;
    logic [ID_W-1:0]   key_reg;
    opt_rec_t          rec_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              pend_reg;
    logic [CNT_W-1:0]  pend_idx_reg;
    logic              res_ok_reg;
    opt_rec_t          res_rec_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              m_ok_reg;

    // memory ports
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    opt_rec_t          mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    opt_rec_t          mem_rd_data;

    logic              hit;
    logic              scan_more;
    logic [CNT_W-1:0]  pend_idx_m1;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

    opt_rec_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // scan status
    assign hit         = pend_reg && (mem_rd_data.id == key_reg);
    assign scan_more   = scan_idx_reg < count_reg;
    assign pend_idx_m1 = pend_idx_reg - ONE_C;
    assign cnt_wide    = {{OUT_CNT_W{1'b0}}, count_reg};

    // memory port control
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[ADDR_W-1:0];
        mem_wr_data = rec_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_EXEC: begin
                // append at the tail
                mem_wr_en = (op_reg == OP_INSERT) && (count_reg < DEPTH_C);
            end
            ST_SCAN: begin
                mem_rd_en = !hit && scan_more;
            end
            ST_SHIFT: begin
                // read entry k, write it back to k-1 in the next cycle
                mem_rd_en   = scan_more;
                mem_wr_en   = pend_reg;
                mem_wr_addr = pend_idx_m1[ADDR_W-1:0];
                mem_wr_data = mem_rd_data;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer, count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= s_tuser;
                        key_reg      <= s_tdata[15:0];
                        rec_reg.id   <= s_tdata[15:0];
                        rec_reg.cpu  <= s_tdata[31:16];
                        rec_reg.io   <= s_tdata[47:32];
                        rec_reg.prio <= s_tdata[55:48];
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    res_ok_reg   <= 1'b0;
                    res_rec_reg  <= '0;
                    scan_idx_reg <= '0;
                    pend_reg     <= 1'b0;
                    unique case (op_reg) inside
                        OP_INSERT: begin
                            if (count_reg < DEPTH_C) begin
                                count_reg  <= count_reg + ONE_C;
                                res_ok_reg <= 1'b1;
                            end
                            state_reg <= ST_RESULT;
                        end
                        OP_DELETE, OP_LOOKUP: begin
                            state_reg <= ST_SCAN;
                        end
                        default: begin
                            state_reg <= ST_RESULT;
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (hit) begin
                        pend_reg <= 1'b0;
                        if (op_reg == OP_LOOKUP) begin
                            res_ok_reg  <= 1'b1;
                            res_rec_reg <= mem_rd_data;
                            state_reg   <= ST_RESULT;
                        end else begin
                            // close the gap starting one past the match
                            scan_idx_reg <= pend_idx_reg + ONE_C;
                            state_reg    <= ST_SHIFT;
                        end
                    end else if (scan_more) begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= scan_idx_reg;
                        scan_idx_reg <= scan_idx_reg + ONE_C;
                    end else begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                end
                ST_SHIFT: begin
                    if (scan_more) begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= scan_idx_reg;
                        scan_idx_reg <= scan_idx_reg + ONE_C;
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            count_reg  <= count_reg - ONE_C;
                            res_ok_reg <= 1'b1;
                            state_reg  <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_ok_reg     <= res_ok_reg;
                        m_tdata_reg  <= {2'b00, (count_reg == '0), cnt_wide[OUT_CNT_W-1:0],
                                         res_rec_reg.prio, res_rec_reg.io,
                                         res_rec_reg.cpu, res_rec_reg.id};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_ok_reg;

    // count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("record count beyond table depth");

    // count moves by at most one per operation step
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + ONE_C) ||
        (count_reg + ONE_C == $past(count_reg)))
        else $error("record count jumped");

    // memory is only written while an operation is in progress
    a_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_EXEC) || (state_reg == ST_SHIFT))
        else $error("memory write outside an operation");

    // a result appears only out of the result state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result beat without a finished operation");

endmodule : ordered_process_table_core

`default_nettype wire

### verif/ordered_process_table_core_test.sv
// Self-checking testbench for the ordered process table core.
`timescale 1ns / 1ps

module ordered_process_table_core_test;
    import opt_pkg::*;

    // Opcode 3 is not decoded by the block: no operation
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 2 * OPT_TABLE_DEPTH + 20;
    localparam int unsigned HOLD_CYCLES = 400;

    // One expected result beat
    typedef struct packed {
        logic       ok;
        opt_rec_t   rec;
        logic [4:0] count;
        logic       empty;
    } table_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // proc_id, cpu_burst_in, io_burst_in, priority_in
    logic [S_TUSER_W-1:0] s_tuser;   // opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // found_id, cpu_burst_out, io_burst_out,
                                     // priority_out, entry_count, is_empty, pad
    logic [M_TUSER_W-1:0] m_tuser;   // ok

    // Shadow copy of the table
    opt_rec_t      shadow_table [OPT_TABLE_DEPTH];
    int unsigned   shadow_count;
    table_result_t pending_results [$];

    int unsigned cycle_count;
    int unsigned failures;
    int unsigned hold_cycles;
    bit          idle_on;

    ordered_process_table_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Apply one accepted operation to the shadow table, queue the expected beat
    function automatic void predict_table_op(logic [1:0] op, opt_rec_t rec);
        table_result_t res;
        int unsigned   pos;
        pos = shadow_count;
        res = '0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
            if (pos == shadow_count && shadow_table[i].id == rec.id) begin
                pos = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (shadow_count < OPT_TABLE_DEPTH) begin
                    shadow_table[shadow_count] = rec;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos < shadow_count) begin
                    // close the gap, keep order
                    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
                        shadow_table[i] = shadow_table[i + 1];
                    end
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (pos < shadow_count) begin
                    res.ok  = 1'b1;
                    res.rec = shadow_table[pos];
                end
            end
            default: ;
        endcase
        res.count = shadow_count[4:0];
        res.empty = (shadow_count == 0);
        pending_results.push_back(res);
    endfunction

    // Send one beat after a random gap when idling is on; predict at acceptance
    task automatic send_op(input logic [1:0] op, input logic [15:0] id,
                           input logic [15:0] cpu, input logic [15:0] io,
                           input logic [7:0] prio);
        int unsigned gap;
        opt_rec_t    rec;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        rec.id   = id;
        rec.cpu  = cpu;
        rec.io   = io;
        rec.prio = prio;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = rec;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_table_op(op, rec);
    endtask

    // Opcode by weights in percent; the remainder goes to the unused code
    function automatic logic [1:0] pick_op(int unsigned w_ins, int unsigned w_del,
                                           int unsigned w_look);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < w_ins) begin
            return OP_INSERT;
        end else if (r < w_ins + w_del) begin
            return OP_DELETE;
        end else if (r < w_ins + w_del + w_look) begin
            return OP_LOOKUP;
        end else begin
            return OP_UNUSED;
        end
    endfunction

    // Ids mostly from a small pool or the table itself, so hits and duplicates are common
    function automatic logic [15:0] pick_id(bit prefer_held);
        logic [15:0] pool [8];
        pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                 16'h00A5, 16'h5A5A, 16'h1234, 16'hFFFE};
        if (prefer_held && shadow_count > 0 && $urandom_range(0, 3) != 0) begin
            return shadow_table[$urandom_range(0, shadow_count - 1)].id;
        end else if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom);
        end else begin
            return pool[$urandom_range(0, 7)];
        end
    endfunction

    task automatic send_random(int unsigned w_ins, int unsigned w_del, int unsigned w_look);
        logic [1:0] op;
        op = pick_op(w_ins, w_del, w_look);
        send_op(op, pick_id(op != OP_INSERT), 16'($urandom), 16'($urandom),
                8'($urandom));
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_result();
        table_result_t want;
        opt_rec_t      got_rec;
        logic [4:0]    got_count;
        logic          got_empty;
        got_rec   = m_tdata[55:0];
        got_count = m_tdata[60:56];
        got_empty = m_tdata[61];
        if (pending_results.size() == 0) begin
            $error("result beat with no expectation waiting");
            failures++;
        end else begin
            want = pending_results.pop_front();
            if (m_tuser[0] !== want.ok) begin
                $error("ok: expected %0d, actual %0d", want.ok, m_tuser[0]);
                failures++;
            end
            if (got_rec.id !== want.rec.id) begin
                $error("found_id: expected %0h, actual %0h", want.rec.id, got_rec.id);
                failures++;
            end
            if (got_rec.cpu !== want.rec.cpu) begin
                $error("cpu_burst_out: expected %0h, actual %0h", want.rec.cpu, got_rec.cpu);
                failures++;
            end
            if (got_rec.io !== want.rec.io) begin
                $error("io_burst_out: expected %0h, actual %0h", want.rec.io, got_rec.io);
                failures++;
            end
            if (got_rec.prio !== want.rec.prio) begin
                $error("priority_out: expected %0h, actual %0h", want.rec.prio, got_rec.prio);
                failures++;
            end
            if (got_count !== want.count) begin
                $error("entry_count: expected %0d, actual %0d", want.count, got_count);
                failures++;
            end
            if (got_empty !== want.empty) begin
                $error("is_empty: expected %0d, actual %0d", want.empty, got_empty);
                failures++;
            end
        end
    endtask

    // Result sink: random stalls, plus a long hold when requested
    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
            end
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_result();
        end
    end

    // Empty table, extremes of every field, duplicates, misses, unused opcode
    task automatic test_directed();
        idle_on = 1'b1;
        send_op(OP_LOOKUP, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_DELETE, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_UNUSED, 16'h0000, 16'h0, 16'h0, 8'h0);
        send_op(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_op(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_op(OP_INSERT, 16'h1234, 16'hAAAA, 16'h5555, 8'hA5);
        send_op(OP_INSERT, 16'h1234, 16'h5555, 16'hAAAA, 8'h5A);
        send_op(OP_LOOKUP, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_op(OP_LOOKUP, 16'hFFFF, 16'h0, 16'h0, 8'h0);
        // the oldest duplicate answers first
        send_op(OP_LOOKUP, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_DELETE, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_LOOKUP, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_LOOKUP, 16'h5555, 16'h0, 16'h0, 8'h0);
        send_op(OP_DELETE, 16'h5555, 16'h0, 16'h0, 8'h0);
        send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_op(OP_DELETE, 16'h0000, 16'h0, 16'h0, 8'h0);
        send_op(OP_DELETE, 16'hFFFF, 16'h0, 16'h0, 8'h0);
        send_op(OP_DELETE, 16'h1234, 16'h0, 16'h0, 8'h0);
        send_op(OP_LOOKUP, 16'h0000, 16'h0, 16'h0, 8'h0);
    endtask

    // Mixed traffic in blocks, idling switched on and off per block
    task automatic test_random_mix(int unsigned n_items);
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random(40, 25, 30);
        end
    endtask

    // Fill past full, then drain to empty, several rounds
    task automatic test_fill_drain(int unsigned rounds);
        for (int unsigned r = 0; r < rounds; r++) begin
            idle_on = (r % 2 == 0);
            for (int unsigned i = 0; i < OPT_TABLE_DEPTH + 4; i++) begin
                send_random(85, 5, 8);
            end
            while (shadow_count > 0) begin
                send_random(5, 60, 33);
            end
        end
    endtask

    // Sink holds off while the sender keeps offering beats back to back
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_cycles = HOLD_CYCLES;
        for (int unsigned i = 0; i < 20; i++) begin
            send_random(50, 20, 25);
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        shadow_count = 0;
        failures     = 0;
        hold_cycles  = 0;
        idle_on      = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_mix(200);
        test_fill_drain(4);
        test_backpressure();
        test_random_mix(100);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
